[rtl/lirf_pkg.sv]
// ----------------------------------------------------------------------------
// lirf_pkg
// Shared constants, register indexes and the job type of the resampler.
// ----------------------------------------------------------------------------
package lirf_pkg;

  localparam int SampleBits = 16;
  localparam int FadeLen    = 200;
  localparam int MaxResults = 32;
  localparam int FracBits   = 16;
  localparam int PhaseBits  = FracBits + 1;
  localparam int StepBits   = 17;
  localparam int LenBits    = 24;
  localparam int CfgAddrW   = 1;
  localparam int CfgDataW   = 24;

  localparam int FadeW = $clog2(FadeLen + 1);
  localparam int NW    = $clog2(MaxResults + 1);

  localparam logic [CfgAddrW-1:0] RegPhaseStep    = 1'd0;
  localparam logic [CfgAddrW-1:0] RegOutputLength = 1'd1;

  // Job queue
  localparam int QDepth = 4;
  localparam int QAW    = $clog2(QDepth);

  // Datapath widths
  localparam int SumW = SampleBits + FracBits + 1;
  localparam int MagW = SampleBits + FracBits;
  localparam int P1W  = MagW + FadeW;
  localparam int P2W  = MagW + 2 * FadeW;
  localparam int QuoW = SampleBits;

  // Gain denominator is FadeLen squared; the phase scale is a plain shift.
  localparam longint unsigned FadeDen   = longint'(FadeLen) * longint'(FadeLen);
  localparam longint unsigned RoundHalf = (longint'(1) << FracBits) * FadeDen / 2;
  localparam int MW = $clog2(((longint'(1) << (SampleBits - 1)) + 1) * FadeDen);
  localparam int RecipK = MW + $clog2(FadeDen);
  localparam longint unsigned Recip = ((longint'(1) << RecipK) + FadeDen - 1) / FadeDen;
  localparam int RW    = $clog2(Recip + 1);
  localparam int ProdW = MW + RW;

  typedef struct packed {
    logic signed [SampleBits-1:0] prev;
    logic signed [SampleBits-1:0] cur;
    logic [FracBits-1:0]          frac;
    logic [FadeW-1:0]             gain_in;
    logic [FadeW-1:0]             gain_out;
    logic                         last;
  } job_t;

endpackage

[rtl/lirf_fifo.sv]
// ----------------------------------------------------------------------------
// lirf_fifo
// Short job queue between the sequencer and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module lirf_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lirf_pkg::job_t  data_i,
  input  logic            pop_i,
  output lirf_pkg::job_t  data_o,
  output logic            full_o,
  output logic            empty_o
);

  lirf_pkg::job_t                 mem_q [lirf_pkg::QDepth];
  logic [lirf_pkg::QAW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [lirf_pkg::QAW:0]         cnt_q;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (lirf_pkg::QAW + 1)'(lirf_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

[rtl/lirf_front.sv]
// ----------------------------------------------------------------------------
// lirf_front
// Accepts source samples, tracks phase and output count, and issues one job
// per output sample into the queue.
// ----------------------------------------------------------------------------
module lirf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic signed [lirf_pkg::SampleBits-1:0] sample_i,
  input  logic                                is_last_i,
  input  logic [lirf_pkg::StepBits-1:0]       step_i,
  input  logic [lirf_pkg::LenBits-1:0]        len_i,
  input  logic                                full_i,
  output logic                                push_o,
  output lirf_pkg::job_t                      job_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_IVAL = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  logic [1:0]                              state_q, state_d;
  logic signed [lirf_pkg::SampleBits-1:0]  prev_q, prev_d, cur_q, cur_d;
  logic [lirf_pkg::PhaseBits:0]            phase_q, phase_d;
  logic [lirf_pkg::LenBits-1:0]            count_q, count_d;
  logic [lirf_pkg::NW-1:0]                 n_q, n_d;
  logic                                    first_q, first_d;
  logic                                    last_in_q, last_in_d;

  logic                                    cnt_lt, n_lt, ival_go, tail_go, emit_go, tail_done;
  logic                                    phase_wrap;
  logic [lirf_pkg::PhaseBits:0]            phase_sum;
  logic [lirf_pkg::LenBits:0]              count_inc;
  logic [lirf_pkg::LenBits-1:0]            rem;

  assign cnt_lt     = count_q < len_i;
  assign n_lt       = n_q != lirf_pkg::NW'(lirf_pkg::MaxResults);
  assign phase_wrap = |phase_q[lirf_pkg::PhaseBits:lirf_pkg::FracBits];
  assign ival_go    = !phase_wrap && cnt_lt && n_lt;
  assign tail_go    = cnt_lt && n_lt;
  assign emit_go    = ((state_q == ST_IVAL) && ival_go) || ((state_q == ST_TAIL) && tail_go);
  assign push_o     = emit_go && !full_i;
  assign tail_done  = (state_q == ST_TAIL) && !tail_go;
  assign phase_sum  = phase_q + (lirf_pkg::PhaseBits + 1)'(step_i);
  assign count_inc  = {1'b0, count_q} + 1'b1;
  assign rem        = len_i - count_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    job_o.prev     = (state_q == ST_TAIL) ? cur_q : prev_q;
    job_o.cur      = cur_q;
    job_o.frac     = (state_q == ST_TAIL) ? '0 : phase_q[lirf_pkg::FracBits-1:0];
    job_o.gain_in  = (count_q < lirf_pkg::LenBits'(lirf_pkg::FadeLen)) ?
                     count_q[lirf_pkg::FadeW-1:0] : lirf_pkg::FadeW'(lirf_pkg::FadeLen);
    job_o.gain_out = (rem < lirf_pkg::LenBits'(lirf_pkg::FadeLen)) ?
                     rem[lirf_pkg::FadeW-1:0] : lirf_pkg::FadeW'(lirf_pkg::FadeLen);
    job_o.last     = (count_inc == {1'b0, len_i}) ||
                     (last_in_q && (n_q == lirf_pkg::NW'(lirf_pkg::MaxResults - 1)));
  end

  always_comb begin
    state_d   = state_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    phase_d   = phase_q;
    count_d   = count_q;
    n_d       = n_q;
    first_d   = first_q;
    last_in_d = last_in_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          cur_d     = sample_i;
          last_in_d = is_last_i;
          n_d       = '0;
          if (!first_q) begin
            first_d = 1'b1;
            phase_d = '0;
            prev_d  = sample_i;
            state_d = is_last_i ? ST_TAIL : ST_IDLE;
          end else begin
            state_d = ST_IVAL;
          end
        end
      end
      ST_IVAL: begin
        if (push_o) begin
          phase_d = phase_sum;
          count_d = count_inc[lirf_pkg::LenBits-1:0];
          n_d     = n_q + 1'b1;
        end else if (!ival_go) begin
          phase_d = phase_wrap ?
                    (phase_q - (lirf_pkg::PhaseBits + 1)'(1 << lirf_pkg::FracBits)) : '0;
          prev_d  = cur_q;
          state_d = last_in_q ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (push_o) begin
          count_d = count_inc[lirf_pkg::LenBits-1:0];
          n_d     = n_q + 1'b1;
        end else if (tail_done) begin
          prev_d  = '0;
          phase_d = '0;
          count_d = '0;
          first_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      prev_q    <= '0;
      cur_q     <= '0;
      phase_q   <= '0;
      count_q   <= '0;
      n_q       <= '0;
      first_q   <= 1'b0;
      last_in_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      prev_q    <= prev_d;
      cur_q     <= cur_d;
      phase_q   <= phase_d;
      count_q   <= count_d;
      n_q       <= n_d;
      first_q   <= first_d;
      last_in_q <= last_in_d;
    end
  end

  a_push_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("job pushed into full queue");

  a_push_in_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (count_q < len_i)) else $error("job issued past output length");

  a_run_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_done |=> ((count_q == '0) && !first_q)) else $error("run state not cleared");

endmodule

[rtl/lirf_back.sv]
// ----------------------------------------------------------------------------
// lirf_back
// Arithmetic pipeline: interpolate, apply fade gains, round, divide by the gain
// denominator, and hold the result in an output register.
// ----------------------------------------------------------------------------
module lirf_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lirf_pkg::job_t                     job_i,
  input  logic                               empty_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic signed [lirf_pkg::SampleBits-1:0] sample_o,
  output logic                               last_o
);

  logic                                 en;
  logic [5:1]                           v_q;
  logic                                 out_valid_q;

  logic signed [lirf_pkg::SampleBits:0] diff;
  logic signed [lirf_pkg::SumW:0]       sum_wide;
  logic [lirf_pkg::SumW-1:0]            s1_abs;
  logic [lirf_pkg::MagW-1:0]            s1_mag;
  logic [lirf_pkg::P2W-1:0]             s3_round;
  logic [lirf_pkg::ProdW-1:0]           s4_prod;

  logic [lirf_pkg::SumW-1:0]            s1_sum_q;
  logic [lirf_pkg::FadeW-1:0]           s1_gin_q, s1_gout_q, s2_gout_q;
  logic [lirf_pkg::P1W-1:0]             s2_p1_q;
  logic [lirf_pkg::P2W-1:0]             s3_p2_q;
  logic [lirf_pkg::MW-1:0]              s4_m_q;
  logic [lirf_pkg::QuoW-1:0]            s5_q_q;
  logic [5:2]                           neg_q;
  logic [5:1]                           last_q;
  logic [lirf_pkg::SampleBits-1:0]      out_data_q;
  logic                                 out_last_q;

  assign en    = !out_valid_q || m_axis_tready_i;
  assign pop_o = en && !empty_i;

  assign diff     = $signed({job_i.cur[lirf_pkg::SampleBits-1], job_i.cur}) -
                    $signed({job_i.prev[lirf_pkg::SampleBits-1], job_i.prev});
  assign sum_wide = $signed({{2{job_i.prev[lirf_pkg::SampleBits-1]}}, job_i.prev,
                    {lirf_pkg::FracBits{1'b0}}}) + diff * $signed({1'b0, job_i.frac});
  assign s1_abs   = s1_sum_q[lirf_pkg::SumW-1] ? (~s1_sum_q + 1'b1) : s1_sum_q;
  assign s1_mag   = s1_abs[lirf_pkg::MagW-1:0];
  assign s3_round = s3_p2_q + lirf_pkg::P2W'(lirf_pkg::RoundHalf);
  assign s4_prod  = lirf_pkg::ProdW'(s4_m_q) * lirf_pkg::ProdW'(lirf_pkg::Recip);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= {v_q[4:1], pop_o};
      out_valid_q <= v_q[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sum_q   <= sum_wide[lirf_pkg::SumW-1:0];
      s1_gin_q   <= job_i.gain_in;
      s1_gout_q  <= job_i.gain_out;
      last_q[1]  <= job_i.last;

      s2_p1_q    <= lirf_pkg::P1W'(s1_mag) * lirf_pkg::P1W'(s1_gin_q);
      s2_gout_q  <= s1_gout_q;
      neg_q[2]   <= s1_sum_q[lirf_pkg::SumW-1];
      last_q[2]  <= last_q[1];

      s3_p2_q    <= lirf_pkg::P2W'(s2_p1_q) * lirf_pkg::P2W'(s2_gout_q);
      neg_q[3]   <= neg_q[2];
      last_q[3]  <= last_q[2];

      s4_m_q     <= s3_round[lirf_pkg::FracBits +: lirf_pkg::MW];
      neg_q[4]   <= neg_q[3];
      last_q[4]  <= last_q[3];

      s5_q_q     <= s4_prod[lirf_pkg::RecipK +: lirf_pkg::QuoW];
      neg_q[5]   <= neg_q[4];
      last_q[5]  <= last_q[4];

      out_data_q <= neg_q[5] ? (~s5_q_q + 1'b1) : s5_q_q;
      out_last_q <= last_q[5];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign sample_o        = $signed(out_data_q);
  assign last_o          = out_last_q;

  a_pop_has_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i) else $error("pop from empty queue");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(v_q)) else $error("pipeline moved on stall");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(v_q[5])) else $error("output without pipeline data");

endmodule

[rtl/linear_interp_resampler_fade.sv]
// ----------------------------------------------------------------------------
// linear_interp_resampler_fade
// Linear-interpolation resampler with fade-in and fade-out over a fixed-length
// output run.
// ----------------------------------------------------------------------------
// A source sample is taken while the sequencer is idle; the sequencer then
// issues one output per cycle, while the queue is not full, into a
// four-entry job queue, then closes the interval (after the last sample, a
// tail state closes the run). The arithmetic pipeline delivers one output
// per cycle while the output is not stalled, from the queue through the
// pipeline registers and an output register, so output stalls do not block
// input until the queue fills. Register 0 is the phase step (unsigned 1.16),
// register 1 the output length; write them only while the block is idle.
module linear_interp_resampler_fade (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] sample_in
  input  logic                             s_axis_tlast,  // is_last
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // [15:0] sample_out
  output logic                             m_axis_tlast,  // last_out
  input  logic                             cfg_we_i,
  input  logic [lirf_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [lirf_pkg::CfgDataW-1:0]    cfg_wdata_i
);

  logic [lirf_pkg::StepBits-1:0]          step_q;
  logic [lirf_pkg::LenBits-1:0]           len_q;
  logic                                   push, pop, full, empty;
  lirf_pkg::job_t                         job_in, job_out;
  logic signed [lirf_pkg::SampleBits-1:0] sample_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lirf_pkg::StepBits'(11886);
      len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        lirf_pkg::RegPhaseStep:    step_q <= cfg_wdata_i[lirf_pkg::StepBits-1:0];
        lirf_pkg::RegOutputLength: len_q  <= cfg_wdata_i[lirf_pkg::LenBits-1:0];
        default: begin
        end
      endcase
    end
  end

  lirf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .sample_i        ($signed(s_axis_tdata)),
    .is_last_i       (s_axis_tlast),
    .step_i          (step_q),
    .len_i           (len_q),
    .full_i          (full),
    .push_o          (push),
    .job_o           (job_in)
  );

  lirf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (full),
    .empty_o (empty)
  );

  lirf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_out),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .sample_o        (sample_out),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = sample_out;

endmodule
